[rtl/sacp_pkg.sv]
// Shared types and constants of the sort-and-count-pairs unit.
`default_nettype none

package sacp_pkg;

    localparam int VALUE_W = 32;    // element width
    localparam int DIFF_W  = 32;    // pair difference register width
    localparam int PAIR_W  = 11;    // pair count width (wraps)

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      is_final;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic [PAIR_W-1:0]         pair_total;
        logic                      overflowed;
        logic                      run_end;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/sacp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sacp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];   // read-old on same-address write
    end

endmodule

`default_nettype wire

[rtl/sort_and_count_pairs_at_difference_unit.sv]
// Top level of the sort-and-count-pairs unit: loader, quicksort sequencer, pair counter.
`default_nettype none

// Collects up to STORE_DEPTH signed 32-bit values, one item per cycle while busy
// is low and start is high; the item with is_final set closes the set (items past
// STORE_DEPTH are dropped and flagged). busy then rises while the set is sorted in
// place with a Lomuto quicksort driven by a range stack held in RAM, and all index
// pairs are checked for an absolute difference equal to pair_difference (pairs of
// equal values never count). Every value is then sent out in ascending order, each
// with an o_result_valid strobe; the final one carries run_end, the pair total and
// overflowed, and busy falls in the same cycle it appears. The receiver cannot
// stall: each result is flagged on o_result_valid for exactly one cycle.
// The unit loads the values, then runs the partition passes, each scanning its
// range and swapping elements through the single read port of the value RAM, then
// counts the pairs row by row and last sends the output; the sort takes longest
// when the data already arrives in order.
// pair_difference may be written only while the unit is idle.

module sort_and_count_pairs_at_difference_unit #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire sacp_pkg::t_in_item          i_item,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [sacp_pkg::DIFF_W-1:0] i_cfg_wr_data,
    output logic                             o_result_valid,
    output sacp_pkg::t_out_item              o_result
);

    import sacp_pkg::*;

    // index width into the store, count width (holds STORE_DEPTH itself)
    localparam int IW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = 2 * IW;                // stack entry {lo, hi}

    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // sequencer states
    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_SINIT    = 5'd1;
    localparam logic [4:0] S_POP      = 5'd2;
    localparam logic [4:0] S_RANGE    = 5'd3;
    localparam logic [4:0] S_PIVOT    = 5'd4;
    localparam logic [4:0] S_SCAN_RD  = 5'd5;
    localparam logic [4:0] S_SCAN_CMP = 5'd6;
    localparam logic [4:0] S_SWP_W1   = 5'd7;
    localparam logic [4:0] S_SWP_W2   = 5'd8;
    localparam logic [4:0] S_FIN_RD   = 5'd9;
    localparam logic [4:0] S_FIN_W1   = 5'd10;
    localparam logic [4:0] S_FIN_W2   = 5'd11;
    localparam logic [4:0] S_PUSH1    = 5'd12;
    localparam logic [4:0] S_PUSH2    = 5'd13;
    localparam logic [4:0] S_CNT_I    = 5'd14;
    localparam logic [4:0] S_CNT_LD   = 5'd15;
    localparam logic [4:0] S_CNT_RD   = 5'd16;
    localparam logic [4:0] S_CNT_CMP  = 5'd17;
    localparam logic [4:0] S_OUT_RD   = 5'd18;
    localparam logic [4:0] S_OUT_EM   = 5'd19;

    // control registers
    logic [4:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;      // elements held
    logic [CW-1:0]     r_sp, n_sp;            // range stack pointer
    logic [PAIR_W-1:0] r_pairs, n_pairs;
    logic              r_drop, n_drop;
    logic [DIFF_W-1:0] r_pair_diff, n_pair_diff;
    logic              r_out_vld, n_out_vld;

    // datapath registers
    logic [IW-1:0]               r_lo, n_lo;
    logic [IW-1:0]               r_hi, n_hi;
    logic [IW-1:0]               r_next, n_next;  // Lomuto store index
    logic [IW-1:0]               r_j, n_j;        // Lomuto scan index
    logic [CW-1:0]               r_ci, n_ci;      // count outer index
    logic [CW-1:0]               r_cj, n_cj;      // count inner index / output index
    logic signed [VALUE_W-1:0]   r_pivot, n_pivot;
    logic [VALUE_W-1:0]          r_vj, n_vj;
    logic [VALUE_W-1:0]          r_vn, n_vn;
    logic signed [VALUE_W-1:0]   r_vi, n_vi;
    t_out_item                   r_out, n_out;

    // memory ports
    logic               val_we;
    logic [IW-1:0]      val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic [IW-1:0]      val_raddr;
    logic [VALUE_W-1:0] val_rdata;
    logic               stk_we;
    logic [IW-1:0]      stk_waddr;
    logic [SW-1:0]      stk_wdata;
    logic [IW-1:0]      stk_raddr;
    logic [SW-1:0]      stk_rdata;

    sacp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_value_store (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (val_waddr),
        .i_wr_data (val_wdata),
        .i_rd_addr (val_raddr),
        .o_rd_data (val_rdata)
    );

    sacp_ram #(
        .WIDTH (SW),
        .DEPTH (STORE_DEPTH)
    ) u_range_stack (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wdata),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rdata)
    );

    // pair test: exact 33-bit difference against +k and -k in parallel
    logic signed [VALUE_W:0] diff;
    logic signed [VALUE_W:0] k_pos;
    logic signed [VALUE_W:0] k_neg;
    logic                    pair_hit;

    assign k_pos    = $signed({1'b0, r_pair_diff});
    assign k_neg    = -k_pos;
    assign diff     = $signed({r_vi[VALUE_W-1], r_vi})
                    - $signed({val_rdata[VALUE_W-1], val_rdata});
    assign pair_hit = (diff != '0) && ((diff == k_pos) || (diff == k_neg));

    // wider views for index arithmetic
    logic [IW:0]   j_inc;
    logic [IW:0]   p_inc;
    logic [IW:0]   lo_inc;
    logic [CW-1:0] n_m1;
    logic          out_last;

    assign j_inc    = {1'b0, r_j} + (IW+1)'(1);
    assign p_inc    = {1'b0, r_next} + (IW+1)'(1);
    assign lo_inc   = {1'b0, r_lo} + (IW+1)'(1);
    assign n_m1     = r_count - ONE_C;
    assign out_last = ((r_cj + ONE_C) == r_count);

    assign busy = (r_state != S_LOAD);

    // top-of-stack address for a pop
    function automatic logic [IW-1:0] n_sp_dec(input logic [CW-1:0] sp);
        logic [CW-1:0] dec;
        dec      = sp - ONE_C;
        n_sp_dec = dec[IW-1:0];
    endfunction

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sp        = r_sp;
        n_pairs     = r_pairs;
        n_drop      = r_drop;
        n_pair_diff = i_cfg_wr_en ? i_cfg_wr_data : r_pair_diff;
        n_out_vld   = 1'b0;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_next      = r_next;
        n_j         = r_j;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_pivot     = r_pivot;
        n_vj        = r_vj;
        n_vn        = r_vn;
        n_vi        = r_vi;
        n_out       = r_out;

        val_we    = 1'b0;
        val_waddr = r_count[IW-1:0];
        val_wdata = i_item.sample_value;
        val_raddr = r_j;
        stk_we    = 1'b0;
        stk_waddr = r_sp[IW-1:0];
        stk_wdata = {r_lo, r_hi};
        stk_raddr = r_sp[IW-1:0];

        case (r_state)
            S_LOAD: begin
                if (start) begin
                    if (r_count < DEPTH_C) begin
                        val_we  = 1'b1;
                        n_count = r_count + ONE_C;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_item.is_final) begin
                        n_state = S_SINIT;
                    end
                end
            end
            S_SINIT: begin
                n_ci = '0;
                if (r_count < CW'(2)) begin
                    n_sp    = '0;
                    n_state = S_CNT_I;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {IW'(0), n_m1[IW-1:0]};
                    n_sp      = ONE_C;
                    n_state   = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_ci    = '0;
                    n_state = S_CNT_I;
                end else begin
                    stk_raddr = n_sp_dec(r_sp);
                    n_sp      = r_sp - ONE_C;
                    n_state   = S_RANGE;
                end
            end
            S_RANGE: begin
                n_lo = stk_rdata[SW-1:IW];
                n_hi = stk_rdata[IW-1:0];
                if (stk_rdata[SW-1:IW] >= stk_rdata[IW-1:0]) begin
                    n_state = S_POP;
                end else begin
                    val_raddr = stk_rdata[IW-1:0];
                    n_next    = stk_rdata[SW-1:IW];
                    n_j       = stk_rdata[SW-1:IW];
                    n_state   = S_PIVOT;
                end
            end
            S_PIVOT: begin
                n_pivot = $signed(val_rdata);
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                val_raddr = r_j;
                n_state   = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if ($signed(val_rdata) < r_pivot) begin
                    n_vj      = val_rdata;
                    val_raddr = r_next;
                    n_state   = S_SWP_W1;
                end else begin
                    n_j     = j_inc[IW-1:0];
                    n_state = (j_inc == {1'b0, r_hi}) ? S_FIN_RD : S_SCAN_RD;
                end
            end
            S_SWP_W1: begin
                val_we    = 1'b1;
                val_waddr = r_next;
                val_wdata = r_vj;
                n_vn      = val_rdata;
                n_state   = S_SWP_W2;
            end
            S_SWP_W2: begin
                val_we    = 1'b1;
                val_waddr = r_j;
                val_wdata = r_vn;
                n_next    = p_inc[IW-1:0];
                n_j       = j_inc[IW-1:0];
                n_state   = (j_inc == {1'b0, r_hi}) ? S_FIN_RD : S_SCAN_RD;
            end
            S_FIN_RD: begin
                val_raddr = r_next;
                n_state   = S_FIN_W1;
            end
            S_FIN_W1: begin
                val_we    = 1'b1;
                val_waddr = r_hi;
                val_wdata = val_rdata;
                n_state   = S_FIN_W2;
            end
            S_FIN_W2: begin
                val_we    = 1'b1;
                val_waddr = r_next;
                val_wdata = r_pivot;
                n_state   = S_PUSH1;
            end
            S_PUSH1: begin
                // right part {p+1, hi}
                if ((p_inc < {1'b0, r_hi}) && (r_sp < DEPTH_C)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {p_inc[IW-1:0], r_hi};
                    n_sp      = r_sp + ONE_C;
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                // left part {lo, p-1}, popped first
                if (({1'b0, r_next} > lo_inc) && (r_sp < DEPTH_C)) begin
                    stk_we    = 1'b1;
                    stk_wdata = {r_lo, r_next - IW'(1)};
                    n_sp      = r_sp + ONE_C;
                end
                n_state = S_POP;
            end
            S_CNT_I: begin
                if ((r_ci + ONE_C) < r_count) begin
                    val_raddr = r_ci[IW-1:0];
                    n_state   = S_CNT_LD;
                end else begin
                    n_cj    = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_CNT_LD: begin
                n_vi    = $signed(val_rdata);
                n_cj    = r_ci + ONE_C;
                n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                val_raddr = r_cj[IW-1:0];
                n_state   = S_CNT_CMP;
            end
            S_CNT_CMP: begin
                if (pair_hit) begin
                    n_pairs = r_pairs + PAIR_W'(1);
                end
                if ((r_cj + ONE_C) < r_count) begin
                    n_cj    = r_cj + ONE_C;
                    n_state = S_CNT_RD;
                end else begin
                    n_ci    = r_ci + ONE_C;
                    n_state = S_CNT_I;
                end
            end
            S_OUT_RD: begin
                val_raddr = r_cj[IW-1:0];
                n_state   = S_OUT_EM;
            end
            S_OUT_EM: begin
                n_out_vld          = 1'b1;
                n_out.sorted_value = $signed(val_rdata);
                n_out.pair_total   = out_last ? r_pairs : '0;
                n_out.overflowed   = r_drop;
                n_out.run_end      = out_last;
                if (out_last) begin
                    // set closed: ready for the next one
                    n_count = '0;
                    n_pairs = '0;
                    n_drop  = 1'b0;
                    n_sp    = '0;
                    n_state = S_LOAD;
                end else begin
                    n_cj    = r_cj + ONE_C;
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_sp        <= '0;
            r_pairs     <= '0;
            r_drop      <= 1'b0;
            r_pair_diff <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_pairs     <= n_pairs;
            r_drop      <= n_drop;
            r_pair_diff <= n_pair_diff;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_next  <= n_next;
        r_j     <= n_j;
        r_ci    <= n_ci;
        r_cj    <= n_cj;
        r_pivot <= n_pivot;
        r_vj    <= n_vj;
        r_vn    <= n_vn;
        r_vi    <= n_vi;
        r_out   <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

`ifndef ASSERT_OFF
    // a result is only launched from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_OUT_EM))
        else $error("result strobe without emit step");

    // busy stays high until the closing result of a set
    a_busy_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.run_end) |-> busy)
        else $error("unit idle in the middle of a result run");

    // closing result leaves the unit idle and empty
    a_clean_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.run_end) |-> (!busy && (r_count == '0)))
        else $error("set not cleared after closing result");

    // element count and stack pointer never pass the store depth
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_C) && (r_sp <= DEPTH_C))
        else $error("element count or stack pointer out of range");
`endif

endmodule

`default_nettype wire
